// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the escape decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off while in reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ced_pkg.sv =====
// Types and constants shared by the C escape decoder modules.
package ced_pkg;

    localparam int unsigned VALUE_W = 63;

    // Scan modes of the escape parser.
    typedef enum logic [2:0] {
        MODE_NORMAL   = 3'd0,
        MODE_ESCAPE   = 3'd1,
        MODE_HEXFIRST = 3'd2,
        MODE_HEXMORE  = 3'd3,
        MODE_OCTAL    = 3'd4
    } t_mode;

    // Kind tags carried with each result.
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_HEX   = 2'd1,
        KIND_OCTAL = 2'd2
    } t_kind;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        t_mode               mode;
        logic [VALUE_W-1:0]  acc;
        logic [1:0]          octal_count;
    } t_state;

    // One decoded result word.
    typedef struct packed {
        logic [VALUE_W-1:0]  char_value;
        t_kind               kind;
        logic                bad_escape;
        logic                run_last;
    } t_result;

    // Everything one input byte produces: up to two results and the next state.
    typedef struct packed {
        t_state              next;
        logic [1:0]          count;
        t_result             res0;
        t_result             res1;
    } t_step;

    // Up to two results buffered for one input byte.
    typedef struct packed {
        t_result             res0;
        t_result             res1;
        logic                two;
    } t_pair;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

endpackage

// ===== rtl/c_escape_decoder_unit.sv =====
// Top level of the C escape decoder: parser state, result buffer and handshakes.
//
// The unit takes one byte of a C literal body per cycle while it does not
// stall, and decodes it in the same cycle against the parser state; the
// result words of an accepted byte are registered into the result buffer. A
// byte yields zero, one or two result words; a two-entry buffer of result pairs
// holds them, and input stall rises only when both entries are occupied. With
// the output side always ready, bytes that yield at most one word flow at one
// per cycle; a byte that yields two words hands them to the output port one
// after the other, so the sustained rate is set by the single output port at
// one word per cycle.
`include "assert_macros.svh"

module c_escape_decoder_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_end_of_text,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ced_pkg::VALUE_W-1:0] o_char_value,
    output logic [1:0]                  o_kind,
    output logic                        o_bad_escape,
    output logic                        o_run_last
);
    import ced_pkg::*;

    t_state      r_state;
    t_step       step;
    t_pair       r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic        r_sub;
    logic [1:0]  r_count;
    logic        in_fire;
    logic        out_fire;
    logic        push;
    logic        pop;
    t_pair       head;
    t_result     cur;

    ced_decode u_decode (
        .i_state       (r_state),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_step        (step)
    );

    // Handshake decisions.
    assign o_stall  = (r_count == 2'd2);
    assign in_fire  = i_valid && !o_stall;
    assign o_valid  = (r_count != 2'd0);
    assign out_fire = o_valid && !i_stall;
    assign head     = r_slot[r_rd_ptr];
    assign cur      = r_sub ? head.res1 : head.res0;
    assign push     = in_fire && (step.count != 2'd0);
    assign pop      = out_fire && (r_sub || !head.two);

    assign o_char_value = cur.char_value;
    assign o_kind       = cur.kind;
    assign o_bad_escape = cur.bad_escape;
    assign o_run_last   = cur.run_last;

    // Parser state advances on every accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode        <= MODE_NORMAL;
            r_state.acc         <= '0;
            r_state.octal_count <= 2'd0;
        end else if (in_fire) begin
            r_state <= step.next;
        end
    end

    // Result pair storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= '{res0: step.res0, res1: step.res1,
                                  two: (step.count == 2'd2)};
        end
    end

    // Buffer pointers, occupancy and the word select within the head pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_sub    <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (out_fire) begin
                r_sub <= 1'b1;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    // A malformed escape always reads as a zero plain value.
    `ASSERT_SAME(a_bad_is_zero, o_valid && o_bad_escape, (o_char_value == '0) && (o_kind == KIND_PLAIN), "bad escape word carries a value")
    // The end of the text always leaves the parser outside any escape.
    `ASSERT_NEXT(a_end_resets, in_fire && i_end_of_text, r_state.mode == MODE_NORMAL, "parser not reset after end of text")
    // Inside an octal escape one or two digits are pending.
    `ASSERT_SAME(a_octal_count, r_state.mode == MODE_OCTAL, (r_state.octal_count == 2'd1) || (r_state.octal_count == 2'd2), "octal digit count out of range")
    // The second word of a pair is only selected for a pair that holds two.
    `ASSERT_SAME(a_sub_two, o_valid && r_sub, head.two && o_run_last, "second word selected in a single-word pair")

endmodule

// ===== rtl/ced_decode.sv =====
// Combinational decode of one input byte against the current parser state.
module ced_decode (
    input  ced_pkg::t_state  i_state,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_text,
    output ced_pkg::t_step   o_step
);
    import ced_pkg::*;

    // Hex digit value; valid flag in the top bit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    // Simple escape code; valid flag in the top bit.
    function automatic logic [8:0] simple_escape(input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        case (b)
            8'h27, 8'h22, 8'h3F, 8'h5C: r = {1'b1, b};  // quotes, question mark, backslash
            8'h61: r = {1'b1, 8'd7};   // a
            8'h62: r = {1'b1, 8'd8};   // b
            8'h66: r = {1'b1, 8'd12};  // f
            8'h6E: r = {1'b1, 8'd10};  // n
            8'h72: r = {1'b1, 8'd13};  // r
            8'h74: r = {1'b1, 8'd9};   // t
            8'h76: r = {1'b1, 8'd11};  // v
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    t_state      st;
    t_state      nxt;
    t_result     first_res;
    t_result     again_res;
    t_result     flush_res;
    t_result     bad_res;
    logic        first_v;
    logic        again_v;
    logic        flush_v;
    logic        redo;
    logic [4:0]  hex;
    logic [8:0]  simple;
    logic        is_octal;
    logic [1:0]  cnt;
    t_result     r0;
    t_result     r1;

    assign hex      = hex_digit(i_in_byte);
    assign simple   = simple_escape(i_in_byte);
    assign is_octal = (i_in_byte >= 8'h30) && (i_in_byte <= 8'h37);
    assign bad_res  = '{char_value: '0, kind: KIND_PLAIN, bad_escape: 1'b1, run_last: 1'b0};

    // First pass over the byte in the current mode.
    always_comb begin
        st        = i_state;
        first_v   = 1'b0;
        first_res = '{char_value: '0, kind: KIND_PLAIN, bad_escape: 1'b0, run_last: 1'b0};
        redo      = 1'b0;
        cnt       = 2'd0;
        unique case (i_state.mode)
            MODE_ESCAPE: begin
                if (simple[8]) begin
                    st.mode   = MODE_NORMAL;
                    first_v   = 1'b1;
                    first_res.char_value = VALUE_W'(simple[7:0]);
                end else if (i_in_byte == 8'h78) begin
                    st.mode = MODE_HEXFIRST;
                    st.acc  = '0;
                end else if (is_octal) begin
                    st.mode        = MODE_OCTAL;
                    st.acc         = VALUE_W'(i_in_byte[2:0]);
                    st.octal_count = 2'd1;
                end else begin
                    st.mode   = MODE_NORMAL;
                    first_v   = 1'b1;
                    first_res = bad_res;
                    redo      = 1'b1;
                end
            end
            MODE_HEXFIRST, MODE_HEXMORE: begin
                if (hex[4]) begin
                    // Saturate once a further digit would carry past the top bit.
                    st.acc  = (i_state.acc[VALUE_W-1 -: 4] != 4'd0) ? VALUE_MAX
                              : {i_state.acc[VALUE_W-5:0], hex[3:0]};
                    st.mode = MODE_HEXMORE;
                end else begin
                    first_v = 1'b1;
                    if (i_state.mode == MODE_HEXFIRST) begin
                        first_res = bad_res;
                    end else begin
                        first_res.char_value = i_state.acc;
                        first_res.kind       = KIND_HEX;
                    end
                    st.mode = MODE_NORMAL;
                    st.acc  = '0;
                    redo    = 1'b1;
                end
            end
            MODE_OCTAL: begin
                first_res.kind = KIND_OCTAL;
                if (is_octal) begin
                    cnt = i_state.octal_count + 2'd1;
                    st.acc         = {i_state.acc[VALUE_W-4:0], i_in_byte[2:0]};
                    st.octal_count = cnt;
                    if (cnt == 2'd3) begin
                        first_v   = 1'b1;
                        first_res.char_value = st.acc;
                        st.mode        = MODE_NORMAL;
                        st.acc         = '0;
                        st.octal_count = 2'd0;
                    end
                end else begin
                    first_v   = 1'b1;
                    first_res.char_value = i_state.acc;
                    st.mode        = MODE_NORMAL;
                    st.acc         = '0;
                    st.octal_count = 2'd0;
                    redo           = 1'b1;
                end
            end
            default: begin
                st.mode = MODE_NORMAL;
                if (i_in_byte == 8'h5C) begin
                    st.mode = MODE_ESCAPE;
                end else begin
                    first_v   = 1'b1;
                    first_res.char_value = VALUE_W'(i_in_byte);
                end
            end
        endcase
    end

    // Second pass: a byte handed back is seen again in normal mode.
    always_comb begin
        again_v   = 1'b0;
        again_res = '{char_value: VALUE_W'(i_in_byte), kind: KIND_PLAIN,
                      bad_escape: 1'b0, run_last: 1'b0};
        nxt = st;
        if (redo) begin
            if (i_in_byte == 8'h5C) begin
                nxt.mode = MODE_ESCAPE;
            end else begin
                again_v = 1'b1;
            end
        end

        // Flush whatever escape is still open at the end of the text.
        flush_v   = 1'b0;
        flush_res = '{char_value: nxt.acc, kind: KIND_PLAIN,
                      bad_escape: 1'b0, run_last: 1'b0};
        if (i_end_of_text) begin
            unique case (nxt.mode)
                MODE_ESCAPE, MODE_HEXFIRST: begin
                    flush_v   = 1'b1;
                    flush_res = bad_res;
                end
                MODE_HEXMORE: begin
                    flush_v        = 1'b1;
                    flush_res.kind = KIND_HEX;
                end
                MODE_OCTAL: begin
                    flush_v        = 1'b1;
                    flush_res.kind = KIND_OCTAL;
                end
                default: flush_v = 1'b0;
            endcase
            nxt.mode        = MODE_NORMAL;
            nxt.acc         = '0;
            nxt.octal_count = 2'd0;
        end
    end

    // Pack the valid results in order and mark the last one.
    always_comb begin
        r0 = first_v ? first_res : (again_v ? again_res : flush_res);
        r1 = (first_v && again_v) ? again_res : flush_res;
        o_step.next  = nxt;
        o_step.count = {1'b0, first_v} + {1'b0, again_v} + {1'b0, flush_v};
        if (o_step.count == 2'd1) begin
            r0.run_last = 1'b1;
        end
        if (o_step.count == 2'd2) begin
            r1.run_last = 1'b1;
        end
        o_step.res0 = r0;
        o_step.res1 = r1;
    end

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the C escape decoder unit: random and directed byte streams.
module testbench;
    import ced_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 6;
    localparam int TEXT_BYTES = 1425;
    localparam int HOLD_CYCLES = 80;
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_CYCLES = 400000;
    localparam int PHASE_QUIET = 2;

    // One byte of literal text waiting for the driver, with its traffic controls.
    typedef struct {
        logic [7:0] b;
        logic       eot;
        int         phase;
        bit         drain;
        bit         hold;
    } t_lit_byte;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_in_byte = 8'h00;
    logic                 i_end_of_text = 1'b0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [VALUE_W-1:0]   o_char_value;
    logic [1:0]           o_kind;
    logic                 o_bad_escape;
    logic                 o_run_last;

    t_lit_byte            pending_bytes[$];
    t_result              decoded_words[$];
    t_result              step_words[$];

    // Predicted parser state.
    t_mode                parse_mode = MODE_NORMAL;
    logic [VALUE_W-1:0]   digits_acc = '0;
    logic [1:0]           oct_digits = '0;

    int                   sent_cnt = 0;
    int                   acc_cnt = 0;
    int                   word_cnt = 0;
    int                   hex_cnt = 0;
    int                   octal_cnt = 0;
    int                   bad_cnt = 0;
    int                   sat_cnt = 0;
    int                   mismatches = 0;
    int                   cur_phase = 0;
    int                   hold_reqs = 0;
    int                   hold_seen = 0;
    int                   hold_left = 0;
    int                   gen_phase = 0;
    bit                   next_drain = 1'b0;
    bit                   next_hold = 1'b0;

    c_escape_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_char_value  (o_char_value),
        .o_kind        (o_kind),
        .o_bad_escape  (o_bad_escape),
        .o_run_last    (o_run_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int hex_value(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b - "0");
        if (b >= "a" && b <= "f") return int'(b - "a") + 10;
        if (b >= "A" && b <= "F") return int'(b - "A") + 10;
        return -1;
    endfunction

    function automatic int simple_code(logic [7:0] b);
        case (b)
            "'", "\"", "?", "\\": return int'(b);
            "a": return 7;
            "b": return 8;
            "f": return 12;
            "n": return 10;
            "r": return 13;
            "t": return 9;
            "v": return 11;
            default: return -1;
        endcase
    endfunction

    function automatic void add_word(logic [VALUE_W-1:0] value, t_kind kind, logic bad);
        t_result w;
        w.char_value = value;
        w.kind = kind;
        w.bad_escape = bad;
        w.run_last = 1'b0;
        step_words.push_back(w);
    endfunction

    // Advances the predicted parser by one byte; returns 1 when the byte must be rescanned.
    function automatic bit scan_byte(logic [7:0] b);
        int d;
        logic [63:0] limit;
        d = 0;
        limit = {1'b0, VALUE_MAX};
        case (parse_mode)
            MODE_ESCAPE: begin
                d = simple_code(b);
                if (d >= 0) begin
                    parse_mode = MODE_NORMAL;
                    add_word(VALUE_W'(d), KIND_PLAIN, 1'b0);
                end else if (b == "x") begin
                    parse_mode = MODE_HEXFIRST;
                    digits_acc = '0;
                end else if (b >= "0" && b <= "7") begin
                    parse_mode = MODE_OCTAL;
                    digits_acc = VALUE_W'(b - "0");
                    oct_digits = 2'd1;
                end else begin
                    parse_mode = MODE_NORMAL;
                    add_word('0, KIND_PLAIN, 1'b1);
                    return 1'b1;
                end
                return 1'b0;
            end
            MODE_HEXFIRST, MODE_HEXMORE: begin
                d = hex_value(b);
                if (d >= 0) begin
                    if ({1'b0, digits_acc} > (limit - 64'(d)) / 64'd16)
                        digits_acc = VALUE_MAX;
                    else
                        digits_acc = digits_acc * 16 + VALUE_W'(d);
                    parse_mode = MODE_HEXMORE;
                    return 1'b0;
                end
                if (parse_mode == MODE_HEXFIRST)
                    add_word('0, KIND_PLAIN, 1'b1);
                else
                    add_word(digits_acc, KIND_HEX, 1'b0);
                parse_mode = MODE_NORMAL;
                digits_acc = '0;
                return 1'b1;
            end
            MODE_OCTAL: begin
                if (b >= "0" && b <= "7") begin
                    digits_acc = digits_acc * 8 + VALUE_W'(b - "0");
                    oct_digits = oct_digits + 2'd1;
                    if (oct_digits == 2'd3) begin
                        add_word(digits_acc, KIND_OCTAL, 1'b0);
                        parse_mode = MODE_NORMAL;
                        digits_acc = '0;
                        oct_digits = '0;
                    end
                    return 1'b0;
                end
                add_word(digits_acc, KIND_OCTAL, 1'b0);
                parse_mode = MODE_NORMAL;
                digits_acc = '0;
                oct_digits = '0;
                return 1'b1;
            end
            default: begin
                parse_mode = MODE_NORMAL;
                if (b == "\\")
                    parse_mode = MODE_ESCAPE;
                else
                    add_word(VALUE_W'(b), KIND_PLAIN, 1'b0);
                return 1'b0;
            end
        endcase
    endfunction

    // Predicts the words one accepted byte produces and queues them for checking.
    function automatic void decode_byte(logic [7:0] b, logic eot);
        step_words.delete();
        if (scan_byte(b))
            void'(scan_byte(b));
        if (eot) begin
            case (parse_mode)
                MODE_ESCAPE, MODE_HEXFIRST: add_word('0, KIND_PLAIN, 1'b1);
                MODE_HEXMORE: add_word(digits_acc, KIND_HEX, 1'b0);
                MODE_OCTAL: add_word(digits_acc, KIND_OCTAL, 1'b0);
                default: ;
            endcase
            parse_mode = MODE_NORMAL;
            digits_acc = '0;
            oct_digits = '0;
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].run_last = 1'b1;
        foreach (step_words[i])
            decoded_words.push_back(step_words[i]);
    endfunction

    task automatic push_byte(logic [7:0] b, logic eot);
        t_lit_byte item;
        item.b = b;
        item.eot = eot;
        item.phase = gen_phase;
        item.drain = next_drain;
        item.hold = next_hold;
        next_drain = 1'b0;
        next_hold = 1'b0;
        pending_bytes.push_back(item);
    endtask

    task automatic push_text(string s, bit eot_last);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], eot_last && (i == s.len() - 1));
    endtask

    // Queues one random sequence: mostly well-formed escapes, some plain bytes and noise.
    task automatic gen_sequence();
        string hex_set;
        string esc_set;
        int n;
        hex_set = "0123456789abcdefABCDEF";
        esc_set = "'\"?\\abfnrtv";
        n = 0;
        case ($urandom_range(9))
            0, 1: push_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
            2: begin
                push_byte("\\", $urandom_range(24) == 0);
                push_byte(esc_set[$urandom_range(10)], $urandom_range(24) == 0);
            end
            3, 4: begin
                push_byte("\\", 1'b0);
                push_byte("x", $urandom_range(24) == 0);
                // Now and then a long run that can overflow the value.
                n = ($urandom_range(7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                    push_byte(hex_set[$urandom_range(21)], $urandom_range(24) == 0);
            end
            5, 6: begin
                push_byte("\\", $urandom_range(24) == 0);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    push_byte(8'("0" + $urandom_range(7)), $urandom_range(24) == 0);
            end
            7: begin
                push_byte("\\", $urandom_range(24) == 0);
                push_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
            end
            default: begin
                push_byte("\\", 1'b0);
                push_byte("x", $urandom_range(24) == 0);
                push_byte(8'($urandom_range(255)), $urandom_range(24) == 0);
            end
        endcase
    endtask

    // Driver: offers the next byte once the current one is taken, idling by phase or to drain.
    always @(negedge i_clk) begin
        bit go;
        t_lit_byte item;
        go = 1'b0;
        if (i_rst_n && !(i_valid && acc_cnt != sent_cnt)) begin
            if (pending_bytes.size() != 0) begin
                go = 1'b1;
                if (pending_bytes[0].drain && decoded_words.size() != 0)
                    go = 1'b0;
                else if (pending_bytes[0].phase == 0 && chance(29))
                    go = 1'b0;
                else if (pending_bytes[0].phase == 1 && chance(62))
                    go = 1'b0;
            end
            if (go) begin
                item = pending_bytes.pop_front();
                i_in_byte <= item.b;
                i_end_of_text <= item.eot;
                cur_phase <= item.phase;
                sent_cnt <= sent_cnt + 1;
                if (item.hold)
                    hold_reqs <= hold_reqs + 1;
            end
            i_valid <= go;
        end
    end

    // Receiver: random stall by phase, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES - 1;
            i_stall <= 1'b1;
        end else if (cur_phase == 0) begin
            i_stall <= chance(62);
        end else if (cur_phase == 1) begin
            i_stall <= chance(29);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: checks each delivered word against the oldest prediction, then predicts.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (decoded_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected word value=%h kind=%0d bad=%b last=%b",
                                 o_char_value, o_kind, o_bad_escape, o_run_last);
                end else begin
                    want = decoded_words.pop_front();
                    word_cnt++;
                    if (want.bad_escape) bad_cnt++;
                    if (want.kind == KIND_HEX) hex_cnt++;
                    if (want.kind == KIND_OCTAL) octal_cnt++;
                    if (want.kind == KIND_HEX && want.char_value == VALUE_MAX) sat_cnt++;
                    if (o_char_value !== want.char_value || o_kind !== want.kind
                            || o_bad_escape !== want.bad_escape
                            || o_run_last !== want.run_last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"ERROR: word %0d expected value=%h kind=%0d bad=%b ",
                                      "last=%b, got value=%h kind=%0d bad=%b last=%b"},
                                     word_cnt, want.char_value, want.kind, want.bad_escape,
                                     want.run_last, o_char_value, o_kind, o_bad_escape,
                                     o_run_last);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                decode_byte(i_in_byte, i_end_of_text);
                acc_cnt <= acc_cnt + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        // Directed: byte extremes, escapes of each kind, malformed escapes, early end.
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_text("\\'", 1'b0);
        push_text("\\xAg", 1'b0);
        push_text("\\q", 1'b0);
        push_text("\\8", 1'b0);
        push_text("\\xz", 1'b0);
        push_text("\\177", 1'b0);
        push_text("\\79", 1'b0);
        push_text("\\", 1'b1);
        push_text("\\x", 1'b1);

        // Random sequences in three traffic phases.
        while (pending_bytes.size() < TEXT_BYTES) begin
            if (pending_bytes.size() * 3 / TEXT_BYTES != gen_phase) begin
                gen_phase = pending_bytes.size() * 3 / TEXT_BYTES;
                next_drain = 1'b1;
                next_hold = (gen_phase == PHASE_QUIET);
            end
            if (pending_bytes.size() == 150)
                next_hold = 1'b1;
            gen_sequence();
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every queued byte has been offered and taken.
        while (pending_bytes.size() != 0 || acc_cnt != sent_cnt) @(posedge i_clk);
        while (decoded_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Run covered %0d literal bytes and %0d decoded words:", acc_cnt, word_cnt);
        $display("  %0d hex (%0d saturated), %0d octal, %0d malformed escapes.",
                 hex_cnt, sat_cnt, octal_cnt, bad_cnt);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("testbench failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(2 * HALF_PERIOD * MAX_CYCLES);
        $display("Timeout with %0d words still expected", decoded_words.size());
        $display("testbench failed");
        $finish;
    end

endmodule
